FILE: rtl/sed_pkg.sv
// Shared types and status codes for the string escape decoder.
package sed_pkg;

	typedef struct packed {
		logic [20:0] code_point;
		logic        first;
		logic        end_of_string;
	} sed_in_t;

	typedef struct packed {
		logic [20:0] value;
		logic [2:0]  status;
	} sed_out_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_MATCH    = 3'd1,
		ST_BAD_HEX     = 3'd2,
		ST_TRUNC_UNI   = 3'd3,
		ST_MISSING_LOW = 3'd4,
		ST_BAD_LOW     = 3'd5,
		ST_LOW_RANGE   = 3'd6
	} sed_status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_X    = 2'd1,
		PH_U    = 2'd2,
		PH_LOW  = 2'd3
	} sed_phase_t;

	localparam logic [20:0] CP_QUOTE   = 21'h27;
	localparam logic [20:0] CP_DQUOTE  = 21'h22;
	localparam logic [20:0] CP_BSLASH  = 21'h5C;
	localparam logic [20:0] CP_B       = 21'h62;
	localparam logic [20:0] CP_F       = 21'h66;
	localparam logic [20:0] CP_N       = 21'h6E;
	localparam logic [20:0] CP_R       = 21'h72;
	localparam logic [20:0] CP_T       = 21'h74;
	localparam logic [20:0] CP_V       = 21'h76;
	localparam logic [20:0] CP_ZERO    = 21'h30;
	localparam logic [20:0] CP_ONE     = 21'h31;
	localparam logic [20:0] CP_NINE    = 21'h39;
	localparam logic [20:0] CP_LF      = 21'h0A;
	localparam logic [20:0] CP_CR      = 21'h0D;
	localparam logic [20:0] CP_LS      = 21'h2028;
	localparam logic [20:0] CP_PS      = 21'h2029;
	localparam logic [20:0] CP_X       = 21'h78;
	localparam logic [20:0] CP_U       = 21'h75;

	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;

	localparam logic [2:0] X_DIGITS   = 3'd2;
	localparam logic [2:0] U_DIGITS   = 3'd4;
	localparam logic [2:0] LOW_CHARS  = 3'd6;

endpackage

FILE: rtl/string_escape_decoder.sv
// Top level of the string escape decoder: input register, decode logic, result register.
//
// Usage: the code points that follow a backslash in a string arrive one item
// per cycle, while in_ready is high, on the in_* channel (valid/ready). Set
// first on the code point right after the backslash; set end_of_string on an
// item that marks the end of the string. When an escape is complete the block
// gives one item on the out_* channel: a decoded code point with status 0, or a
// nonzero status with value 0. Items that end no escape give no result.
//
// An accepted item sits in the input register while the decode logic works on
// it; the result register loads from it once the result slot is free.
// Throughput is one item per cycle while no result is stalled; the escape
// state updates in the same cycle as an item leaves the input register.
//
// Reset (arst_n low) empties both registers and returns the decoder to idle
// with no surrogate pending. When the receiver holds out_ready low the result
// stays in place, the input register keeps its item, and in_ready falls only
// once both registers are full.
module string_escape_decoder
	import sed_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sed_in_t  in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output sed_out_t out_item
);

	// Hex digit decode: bit 4 set means the code point is a hex digit.
	function automatic logic [4:0] hex_digit(input logic [20:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 21'h30 && c <= 21'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 21'h41 && c <= 21'h46) || (c >= 21'h61 && c <= 21'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Input register stage.
	logic    valid_s1;
	sed_in_t item_s1;

	// Result register.
	logic     out_valid_q;
	sed_out_t out_item_q;

	// Escape state.
	sed_phase_t  phase_q, phase_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  high_q, high_d;
	logic [2:0]  count_q, count_d;
	logic        bad_q, bad_d;

	logic out_free;
	logic fire;

	// The result slot is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || out_ready;
	assign fire     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// Shared datapath terms for the item in the input register.
	logic [20:0] cp;
	logic [4:0]  hd;
	logic [15:0] acc_shift;
	logic [2:0]  count_inc;
	logic        take_hex;
	logic        char_bad;
	logic [15:0] acc_new;
	logic        bad_new;

	assign cp        = item_s1.code_point;
	assign hd        = hex_digit(cp);
	assign acc_shift = {acc_q[11:0], hd[4] ? hd[3:0] : 4'd0};
	assign count_inc = count_q + 3'd1;

	// In the low group the first two characters are the backslash and the 'u'.
	always_comb begin
		take_hex = 1'b1;
		char_bad = !hd[4];
		if (phase_q == PH_LOW && count_q == 3'd0) begin
			take_hex = 1'b0;
			char_bad = (cp != CP_BSLASH);
		end else if (phase_q == PH_LOW && count_q == 3'd1) begin
			take_hex = 1'b0;
			char_bad = (cp != CP_U);
		end
	end

	assign acc_new = take_hex ? acc_shift : acc_q;
	assign bad_new = bad_q | char_bad;

	logic is_high_new;
	logic is_low_new;

	assign is_high_new = (acc_new >= HI_SURR_MIN) && (acc_new <= HI_SURR_MAX);
	assign is_low_new  = (acc_new >= LO_SURR_MIN) && (acc_new <= LO_SURR_MAX);

	// Next-state logic. Any emitted result returns the group to idle.
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		high_d  = high_q;
		count_d = count_q;
		bad_d   = bad_q;
		if (item_s1.first) begin
			phase_d = PH_IDLE;
			acc_d   = 16'd0;
			count_d = 3'd0;
			bad_d   = 1'b0;
			high_d  = 10'd0;
			if (!item_s1.end_of_string && cp == CP_X) begin
				phase_d = PH_X;
			end else if (!item_s1.end_of_string && cp == CP_U) begin
				phase_d = PH_U;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					acc_d   = 16'd0;
					count_d = 3'd0;
					bad_d   = 1'b0;
				end
				PH_X, PH_U, PH_LOW: begin
					acc_d   = acc_new;
					count_d = count_inc;
					bad_d   = bad_new;
					if (item_s1.end_of_string) begin
						phase_d = PH_IDLE;
					end else if (phase_q == PH_X && count_inc >= X_DIGITS) begin
						phase_d = PH_IDLE;
					end else if (phase_q == PH_LOW && count_inc >= LOW_CHARS) begin
						phase_d = PH_IDLE;
					end else if (phase_q == PH_U && count_inc >= U_DIGITS) begin
						// A valid high surrogate opens the low group.
						phase_d = (!bad_new && is_high_new) ? PH_LOW : PH_IDLE;
						if (!bad_new && is_high_new) begin
							high_d = acc_new[9:0];
						end
					end
					if (phase_d == PH_IDLE || phase_d == PH_LOW) begin
						if (phase_d != phase_q) begin
							acc_d   = 16'd0;
							count_d = 3'd0;
							bad_d   = 1'b0;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Output logic: whether the item ends an escape, and with what result.
	logic     emit;
	sed_out_t res;

	always_comb begin
		emit       = 1'b0;
		res.value  = 21'd0;
		res.status = ST_OK;
		if (item_s1.first) begin
			emit = 1'b1;
			if (item_s1.end_of_string) begin
				res.status = ST_NO_MATCH;
			end else begin
				unique case (cp)
					CP_QUOTE, CP_DQUOTE, CP_BSLASH: res.value = cp;
					CP_B:    res.value = 21'h08;
					CP_F:    res.value = 21'h0C;
					CP_N:    res.value = 21'h0A;
					CP_R:    res.value = 21'h0D;
					CP_T:    res.value = 21'h09;
					CP_V:    res.value = 21'h0B;
					CP_ZERO: res.value = 21'd0;
					CP_LF, CP_CR, CP_LS, CP_PS: res.status = ST_NO_MATCH;
					CP_X, CP_U: emit = 1'b0;
					default: begin
						if (cp >= CP_ONE && cp <= CP_NINE) begin
							res.status = ST_NO_MATCH;
						end else begin
							res.value = cp;
						end
					end
				endcase
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: emit = 1'b0;
				PH_X: begin
					if (item_s1.end_of_string) begin
						emit       = 1'b1;
						res.status = ST_NO_MATCH;
					end else if (count_inc >= X_DIGITS) begin
						emit = 1'b1;
						if (bad_new) begin
							res.status = ST_BAD_HEX;
						end else begin
							res.value = {13'd0, acc_new[7:0]};
						end
					end
				end
				PH_U: begin
					if (item_s1.end_of_string) begin
						emit       = 1'b1;
						res.status = ST_TRUNC_UNI;
					end else if (count_inc >= U_DIGITS) begin
						if (bad_new) begin
							emit       = 1'b1;
							res.status = ST_BAD_HEX;
						end else if (!is_high_new) begin
							emit      = 1'b1;
							res.value = {5'd0, acc_new};
						end
					end
				end
				PH_LOW: begin
					if (item_s1.end_of_string) begin
						emit       = 1'b1;
						res.status = ST_MISSING_LOW;
					end else if (count_inc >= LOW_CHARS) begin
						emit = 1'b1;
						if (bad_new) begin
							res.status = ST_BAD_LOW;
						end else if (is_low_new) begin
							res.value = SUPP_BASE + {1'b0, high_q, acc_new[9:0]};
						end else begin
							res.status = ST_LOW_RANGE;
						end
					end
				end
				default: emit = 1'b0;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Escape state advances only when the input register item is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= 16'd0;
			high_q  <= 10'd0;
			count_q <= 3'd0;
			bad_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			high_q  <= high_d;
			count_q <= count_d;
			bad_q   <= bad_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

FILE: rtl/sed_checker.sv
// Port-level assertions for the string escape decoder, bound to the top level.
module sed_port_assertions
	import sed_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input sed_out_t out_item
);

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed or dropped");

	// Every error result carries a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |-> out_item.value == 21'd0)
		else $error("error result with nonzero value");

	// No status code above the last defined one.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status <= ST_LOW_RANGE)
		else $error("undefined status code");

	// With an empty output side the block always takes input.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(in_valid && in_ready) |-> in_ready)
		else $error("input stalled with both registers free");

endmodule

bind string_escape_decoder sed_port_assertions u_sed_port_assertions (.*);

FILE: verif/sed_checker.sv
// Checker for the string escape decoder: predicts each result and compares it.
`timescale 1ns / 100ps

module sed_checker
	import sed_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  sed_in_t  in_item,
	input  logic     out_valid,
	input  logic     out_ready,
	input  sed_out_t out_item,
	output int       error_count,
	output int       outstanding
);

	localparam logic [20:0] CP_UPPER_A = 21'h41;
	localparam logic [20:0] CP_UPPER_F = 21'h46;
	localparam logic [20:0] CP_LOWER_A = 21'h61;
	localparam logic [20:0] CP_LOWER_F = 21'h66;

	// Control characters produced by the single escapes.
	localparam logic [20:0] CTRL_BS = 21'h08;
	localparam logic [20:0] CTRL_HT = 21'h09;
	localparam logic [20:0] CTRL_LF = 21'h0A;
	localparam logic [20:0] CTRL_VT = 21'h0B;
	localparam logic [20:0] CTRL_FF = 21'h0C;
	localparam logic [20:0] CTRL_CR = 21'h0D;

	sed_phase_t  esc_phase;
	logic [15:0] hex_acc;
	logic [15:0] high_half;
	int unsigned group_len;
	logic        group_bad;
	sed_out_t    expected_results[$];

	initial error_count = 0;

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		error_count++;
	endtask

	// Bit 4 set means the character is not a hex digit.
	function automatic logic [4:0] nibble_of(input logic [20:0] c);
		if (c >= CP_ZERO && c <= CP_NINE) return 5'(c - CP_ZERO);
		if (c >= CP_UPPER_A && c <= CP_UPPER_F) return 5'(c - CP_UPPER_A + 21'd10);
		if (c >= CP_LOWER_A && c <= CP_LOWER_F) return 5'(c - CP_LOWER_A + 21'd10);
		return 5'd16;
	endfunction

	function automatic sed_out_t make_result(input logic [20:0] v, input sed_status_t s);
		sed_out_t r;
		r.value = v;
		r.status = s;
		return r;
	endfunction

	task automatic open_group(input sed_phase_t p);
		esc_phase = p;
		hex_acc = '0;
		group_len = 0;
		group_bad = 1'b0;
	endtask

	task automatic shift_nibble(input logic [20:0] c);
		logic [4:0] d;
		d = nibble_of(c);
		if (d[4]) begin
			group_bad = 1'b1;
			d = '0;
		end
		hex_acc = {hex_acc[11:0], d[3:0]};
	endtask

	task automatic decode_escape_step(input sed_in_t it, output bit produced,
			output sed_out_t res);
		logic [20:0] cp;
		cp = it.code_point;
		produced = 1'b1;
		res = '0;
		if (it.first) begin
			open_group(PH_IDLE);
			high_half = '0;
			if (it.end_of_string) begin
				res = make_result('0, ST_NO_MATCH);
			end else begin
				case (cp)
					CP_QUOTE, CP_DQUOTE, CP_BSLASH: res = make_result(cp, ST_OK);
					CP_B: res = make_result(CTRL_BS, ST_OK);
					CP_F: res = make_result(CTRL_FF, ST_OK);
					CP_N: res = make_result(CTRL_LF, ST_OK);
					CP_R: res = make_result(CTRL_CR, ST_OK);
					CP_T: res = make_result(CTRL_HT, ST_OK);
					CP_V: res = make_result(CTRL_VT, ST_OK);
					CP_ZERO: res = make_result('0, ST_OK);
					CP_LF, CP_CR, CP_LS, CP_PS: res = make_result('0, ST_NO_MATCH);
					CP_X: begin
						open_group(PH_X);
						produced = 1'b0;
					end
					CP_U: begin
						open_group(PH_U);
						produced = 1'b0;
					end
					default: begin
						if (cp >= CP_ONE && cp <= CP_NINE) res = make_result('0, ST_NO_MATCH);
						else res = make_result(cp, ST_OK);
					end
				endcase
			end
		end else begin
			case (esc_phase)
				PH_X: begin
					if (it.end_of_string) begin
						res = make_result('0, ST_NO_MATCH);
					end else begin
						shift_nibble(cp);
						group_len++;
						if (group_len < X_DIGITS) produced = 1'b0;
						else if (group_bad) res = make_result('0, ST_BAD_HEX);
						else res = make_result(21'(hex_acc), ST_OK);
					end
				end
				PH_U: begin
					if (it.end_of_string) begin
						res = make_result('0, ST_TRUNC_UNI);
					end else begin
						shift_nibble(cp);
						group_len++;
						if (group_len < U_DIGITS) begin
							produced = 1'b0;
						end else if (group_bad) begin
							res = make_result('0, ST_BAD_HEX);
						end else if (hex_acc >= HI_SURR_MIN && hex_acc <= HI_SURR_MAX) begin
							high_half = hex_acc;
							open_group(PH_LOW);
							produced = 1'b0;
						end else begin
							res = make_result(21'(hex_acc), ST_OK);
						end
					end
				end
				PH_LOW: begin
					if (it.end_of_string) begin
						res = make_result('0, ST_MISSING_LOW);
					end else begin
						if (group_len == 0) begin
							if (cp != CP_BSLASH) group_bad = 1'b1;
						end else if (group_len == 1) begin
							if (cp != CP_U) group_bad = 1'b1;
						end else begin
							shift_nibble(cp);
						end
						group_len++;
						if (group_len < LOW_CHARS) begin
							produced = 1'b0;
						end else if (group_bad) begin
							res = make_result('0, ST_BAD_LOW);
						end else if (hex_acc >= LO_SURR_MIN && hex_acc <= LO_SURR_MAX) begin
							// The ten payload bits of each half sit side by side.
							res = make_result(SUPP_BASE + 21'({high_half[9:0], hex_acc[9:0]}),
								ST_OK);
						end else begin
							res = make_result('0, ST_LOW_RANGE);
						end
					end
				end
				default: produced = 1'b0;
			endcase
		end
		if (produced) open_group(PH_IDLE);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		bit       produced;
		sed_out_t predicted;
		sed_out_t oldest;
		if (!arst_n) begin
			open_group(PH_IDLE);
			high_half = '0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready) begin
				decode_escape_step(in_item, produced, predicted);
				if (produced) expected_results.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					flag_mismatch($sformatf("result with nothing expected: value %h status %0d",
						out_item.value, out_item.status));
				end else begin
					oldest = expected_results.pop_front();
					if (out_item.value !== oldest.value)
						flag_mismatch($sformatf("value %h, expected %h", out_item.value,
							oldest.value));
					if (out_item.status !== oldest.status)
						flag_mismatch($sformatf("status %0d, expected %0d", out_item.status,
							oldest.status));
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
// Top of the string escape decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top
	import sed_pkg::*;
();

	// Random items per idling phase; the four phases give at least 1560 in all.
	localparam int ITEMS_PER_PHASE = 390;
	// Length of the one long receiver hold-off that fills the block up.
	localparam int HOLD_CYCLES = 160;
	// Wait at the end for the block to drain, with plenty of margin.
	localparam int TAIL_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT = 200000;

	localparam logic [20:0] CP_UPPER_A = 21'h41;
	localparam logic [20:0] CP_LOWER_A = 21'h61;

	// Characters next to the hex digit ranges: '/', ':', '@', 'G', '`', 'g'.
	localparam logic [20:0] NEAR_HEX [6] = '{21'h2F, 21'h3A, 21'h40, 21'h47, 21'h60, 21'h67};
	// Everything that has its own meaning right after the backslash, besides x and u.
	localparam logic [20:0] SINGLE_LEADS [10] = '{CP_QUOTE, CP_DQUOTE, CP_BSLASH, CP_B, CP_F,
		CP_N, CP_R, CP_T, CP_V, CP_ZERO};
	localparam logic [20:0] LINE_ENDS [4] = '{CP_LF, CP_CR, CP_LS, CP_PS};
	// Code points at the edges of the ranges the decoder distinguishes.
	localparam logic [20:0] EDGE_LEADS [7] = '{21'h1FFFFF, 21'h10FFFF, 21'h110000, 21'h2027,
		21'h202A, 21'h2F, 21'h3A};
	localparam logic [15:0] EDGE_UNITS [8] = '{16'h0000, 16'hFFFF, 16'hD7FF, 16'hD800,
		16'hDBFF, 16'hDC00, 16'hDFFF, 16'hE000};

	logic     clk;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	sed_in_t  in_item = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	sed_out_t out_item;

	int          error_count;
	int          outstanding;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	bit          hold_go = 1'b0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;

	string_escape_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	sed_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic sed_in_t item_of(input logic [20:0] cp, input logic starts,
			input logic ends);
		sed_in_t it;
		it.code_point = cp;
		it.first = starts;
		it.end_of_string = ends;
		return it;
	endfunction

	function automatic logic [20:0] digit_char(input logic [3:0] d, input bit upper);
		if (d < 4'd10) return CP_ZERO + 21'(d);
		return (upper ? CP_UPPER_A : CP_LOWER_A) + 21'(d - 4'd10);
	endfunction

	function automatic logic [20:0] hex_char(input logic [3:0] d);
		return digit_char(d, bit'($urandom_range(1)));
	endfunction

	// A character that is never a hex digit, a backslash or a 'u'. Setting a bit
	// at position 7 or above on a hex digit catches a decoder that only looks at
	// the low byte.
	function automatic logic [20:0] junk_char();
		case ($urandom_range(2))
			0: return 21'($urandom) | 21'h80;
			1: return NEAR_HEX[$urandom_range(5)];
			default: return hex_char(4'($urandom)) | (21'h1 << $urandom_range(20, 7));
		endcase
	endfunction

	// The character right after the backslash for an escape of a single character.
	function automatic logic [20:0] lead_char();
		case ($urandom_range(5))
			0: return SINGLE_LEADS[$urandom_range(9)];
			1: return CP_ONE + 21'($urandom_range(8));
			2: return LINE_ENDS[$urandom_range(3)];
			3: return 21'($urandom);
			4: return 21'($urandom_range(127));
			default: return EDGE_LEADS[$urandom_range(6)];
		endcase
	endfunction

	// Presents one item and returns once it has been accepted. The sender may
	// idle first, and valid stays high with the same payload until acceptance.
	task automatic offer_item(input sed_in_t it, input bit counted);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		if (counted) items_sent++;
	endtask

	// Sends one character of a group, unless the string ends here or the escape
	// is cut off by a restart. In both of those cases went comes back low.
	task automatic send_group_char(input logic [20:0] cp, output bit went);
		int unsigned roll;
		roll = $urandom_range(99);
		went = 1'b0;
		if (roll < 2) begin
			offer_item(item_of(21'($urandom), 1'b0, 1'b1), 1'b1);
		end else if (roll >= 3) begin
			offer_item(item_of(cp, 1'b0, 1'b0), 1'b1);
			went = 1'b1;
		end
	endtask

	// Sends the hex digits of code_unit, most significant first, now and then with
	// a malformed digit. Returns high only when the whole group went out clean.
	task automatic send_hex_group(input logic [15:0] code_unit, input int digits,
			output bit clean);
		bit went;
		bit bad;
		bad = 1'b0;
		clean = 1'b0;
		for (int i = digits - 1; i >= 0; i--) begin
			if ($urandom_range(99) < 5) begin
				send_group_char(junk_char(), went);
				bad = 1'b1;
			end else begin
				send_group_char(hex_char(code_unit[4*i +: 4]), went);
			end
			if (!went) return;
		end
		clean = !bad;
	endtask

	// One escape with random content. Most are well formed so that the
	// surrogate pair path gets plenty of traffic; the rest are cut short,
	// malformed, or stray items that the block should ignore.
	task automatic send_random_escape();
		int unsigned kind;
		logic [15:0] code_unit;
		bit          clean;
		bit          went;
		kind = $urandom_range(99);
		if (kind < 28) begin
			if ($urandom_range(99) < 4) offer_item(item_of(21'($urandom), 1'b1, 1'b1), 1'b1);
			else offer_item(item_of(lead_char(), 1'b1, 1'b0), 1'b1);
		end else if (kind < 46) begin
			offer_item(item_of(CP_X, 1'b1, 1'b0), 1'b1);
			send_hex_group(16'($urandom), 2, clean);
		end else if (kind < 94) begin
			offer_item(item_of(CP_U, 1'b1, 1'b0), 1'b1);
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: code_unit = HI_SURR_MIN + 16'($urandom_range(16'h3FF));
				9, 10, 11, 12, 13: code_unit = 16'($urandom);
				14, 15, 16: code_unit = LO_SURR_MIN + 16'($urandom_range(16'h3FF));
				default: code_unit = EDGE_UNITS[$urandom_range(7)];
			endcase
			send_hex_group(code_unit, 4, clean);
			if (clean && code_unit >= HI_SURR_MIN && code_unit <= HI_SURR_MAX) begin
				// The low half: backslash, 'u', then four hex digits.
				send_group_char(($urandom_range(99) < 92) ? CP_BSLASH : junk_char(), went);
				if (!went) return;
				send_group_char(($urandom_range(99) < 92) ? CP_U : junk_char(), went);
				if (!went) return;
				if ($urandom_range(99) < 75)
					code_unit = LO_SURR_MIN + 16'($urandom_range(16'h3FF));
				else if ($urandom_range(1))
					code_unit = EDGE_UNITS[$urandom_range(7)];
				else
					code_unit = 16'($urandom);
				send_hex_group(code_unit, 4, clean);
			end
		end else begin
			// Stray items between escapes do not count toward the item budget.
			repeat ($urandom_range(3, 1))
				offer_item(item_of(21'($urandom), 1'b0, bit'($urandom_range(1))), 1'b0);
		end
	endtask

	// Receiver: stalls at the rate of the current phase, and once, when asked,
	// holds off for a long stretch so that both registers of the block fill up
	// and in_ready drops while the sender keeps offering items.
	initial begin : receiver
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int unsigned phase_idle [4];
		int unsigned phase_stall [4];
		sed_in_t     directed[$];

		phase_idle = '{0, 51, 0, 37};
		phase_stall = '{0, 0, 51, 37};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the zero escape, a digit, a line terminator, the
		// largest code point a field can carry, an end right after the
		// backslash, stray items while idle, a full and a short \x, a high
		// surrogate left without its low half, and a lone low surrogate.
		directed.push_back(item_of(CP_ZERO, 1'b1, 1'b0));
		directed.push_back(item_of(CP_ONE + 21'd4, 1'b1, 1'b0));
		directed.push_back(item_of(CP_LF, 1'b1, 1'b0));
		directed.push_back(item_of(21'h1FFFFF, 1'b1, 1'b0));
		directed.push_back(item_of(21'h0, 1'b1, 1'b0));
		directed.push_back(item_of(21'h1FFFFF, 1'b1, 1'b1));
		directed.push_back(item_of(CP_N, 1'b1, 1'b0));
		directed.push_back(item_of(21'h1FFFFF, 1'b0, 1'b0));
		directed.push_back(item_of(21'h0, 1'b0, 1'b1));
		directed.push_back(item_of(CP_X, 1'b1, 1'b0));
		directed.push_back(item_of(digit_char(4'hF, 1'b1), 1'b0, 1'b0));
		directed.push_back(item_of(digit_char(4'hF, 1'b0), 1'b0, 1'b0));
		directed.push_back(item_of(CP_X, 1'b1, 1'b0));
		directed.push_back(item_of(21'h0, 1'b0, 1'b1));
		directed.push_back(item_of(CP_U, 1'b1, 1'b0));
		directed.push_back(item_of(digit_char(4'hD, 1'b1), 1'b0, 1'b0));
		directed.push_back(item_of(digit_char(4'hB, 1'b1), 1'b0, 1'b0));
		directed.push_back(item_of(digit_char(4'hF, 1'b0), 1'b0, 1'b0));
		directed.push_back(item_of(digit_char(4'hF, 1'b1), 1'b0, 1'b0));
		directed.push_back(item_of(21'h0, 1'b0, 1'b1));
		directed.push_back(item_of(CP_U, 1'b1, 1'b0));
		directed.push_back(item_of(digit_char(4'hD, 1'b0), 1'b0, 1'b0));
		directed.push_back(item_of(digit_char(4'hF, 1'b1), 1'b0, 1'b0));
		directed.push_back(item_of(digit_char(4'hF, 1'b0), 1'b0, 1'b0));
		directed.push_back(item_of(digit_char(4'hF, 1'b1), 1'b0, 1'b0));
		foreach (directed[i]) offer_item(directed[i], 1'b1);

		// Random part, one idling phase after another. The long hold-off
		// comes at the start of the first phase, where the sender never idles.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			if (p == 0) hold_go = 1'b1;
			items_sent = 0;
			while (items_sent < ITEMS_PER_PHASE) send_random_escape();
		end

		in_valid <= 1'b0;
		// One more edge so that the last accepted item shows up in outstanding.
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		// Let the pipeline empty so that a surplus result would still be seen.
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
